/* src/sm4_pkg.sv */
// SM4 package: S-box, constants, round functions, state type.
package sm4_pkg;

    localparam int ROUNDS_DEF = 32;

    localparam logic [31:0] FK0 = 32'ha3b1bac6;
    localparam logic [31:0] FK1 = 32'h56aa3350;
    localparam logic [31:0] FK2 = 32'h677d9197;
    localparam logic [31:0] FK3 = 32'hb27022dc;

    localparam logic [2:0] ADDR_KEY_HIGH = 3'd0;
    localparam logic [2:0] ADDR_KEY_LOW  = 3'd1;
    localparam logic [2:0] ADDR_IV_HIGH  = 3'd2;
    localparam logic [2:0] ADDR_IV_LOW   = 3'd3;
    localparam logic [2:0] ADDR_DECRYPT  = 3'd4;
    localparam logic [2:0] ADDR_CHAIN    = 3'd5;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXPAND,
        ST_ROUND,
        ST_DONE
    } sm4_state_t;

    localparam logic [7:0] SBOX [256] = '{
        8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
        8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
        8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
        8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
        8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
        8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
        8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
        8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
        8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
        8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
        8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
        8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
        8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
        8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
        8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
        8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
    };

    function automatic logic [31:0] tau(input logic [31:0] v);
        tau = {SBOX[v[31:24]], SBOX[v[23:16]], SBOX[v[15:8]], SBOX[v[7:0]]};
    endfunction

    function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
        rotl = (v << n) | (v >> (32 - n));
    endfunction

    function automatic logic [31:0] lin_data(input logic [31:0] b);
        lin_data = b ^ rotl(b, 2) ^ rotl(b, 10) ^ rotl(b, 18) ^ rotl(b, 24);
    endfunction

    function automatic logic [31:0] lin_key(input logic [31:0] b);
        lin_key = b ^ rotl(b, 13) ^ rotl(b, 23);
    endfunction

    // CK byte j of word i is (4i+j)*7 mod 256
    function automatic logic [31:0] ck_word(input logic [4:0] i);
        logic [7:0] base;
        base = {1'b0, i, 2'b00};
        ck_word = {8'(base * 8'd7), 8'((base + 8'd1) * 8'd7),
                   8'((base + 8'd2) * 8'd7), 8'((base + 8'd3) * 8'd7)};
    endfunction

endpackage

/* src/sm4_block_cipher_cbc.sv */
// SM4 ECB/CBC block cipher: round keys in a synchronous memory, one round per cycle.
//
//  channel   | valid     | stall     | payload
//  ----------+-----------+-----------+------------------------------------------
//  in        | in_valid  | in_stall  | block_high, block_low, first_block, final_block
//  out       | out_valid | out_stall | result_high, result_low, result_last
//  cfg       | psel/penable/pwrite | pready=1 | paddr, pwdata, prdata
//
// A block is accepted while the first round key read is fetched from memory, then
// runs the rounds (one round key read per cycle from the round key memory), then
// loads the output register once it is free. After reset, or after a key write,
// the next block first expands the round keys, one key per cycle. One block in flight at a time.
// A finished beat waits in the output register; in_stall is high while busy.
module sm4_block_cipher_cbc
    import sm4_pkg::*;
#(
    parameter int ROUNDS = ROUNDS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [63:0] block_high,
    input  logic [63:0] block_low,
    input  logic        first_block,
    input  logic        final_block,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] result_high,
    output logic [63:0] result_low,
    output logic        result_last
);

    localparam int RW = $clog2(ROUNDS);

    logic [63:0] key_high_reg, key_low_reg, iv_high_reg, iv_low_reg;
    logic        decrypt_reg, chain_reg, keys_ready_reg;
    logic [63:0] chain_hi_reg, chain_lo_reg;

    sm4_state_t  state_reg, state_next;
    logic [RW:0] cnt_reg, cnt_next;
    logic [31:0] x_reg [4];
    logic [31:0] x_next [4];
    logic [63:0] blk_hi_reg, blk_lo_reg;
    logic        last_reg;
    logic [63:0] ohi_reg, olo_reg;
    logic        oval_reg;

    logic [31:0] rk_mem [ROUNDS];
    logic [31:0] rk_rd;
    logic [RW-1:0] rd_addr;
    logic        wr_en;
    logic [RW-1:0] wr_addr;
    logic [31:0] wr_data;

    logic        cfg_wr;
    logic [2:0]  cfg_idx;
    logic        in_acc;
    logic [31:0] t_word, f_word;
    logic [63:0] fin_hi, fin_lo;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[5:3];
    assign in_stall = (state_reg != ST_IDLE);
    assign in_acc  = in_valid && !in_stall;

    always_comb
    begin
        case (cfg_idx)
            ADDR_KEY_HIGH: prdata = key_high_reg;
            ADDR_KEY_LOW:  prdata = key_low_reg;
            ADDR_IV_HIGH:  prdata = iv_high_reg;
            ADDR_IV_LOW:   prdata = iv_low_reg;
            ADDR_DECRYPT:  prdata = {63'd0, decrypt_reg};
            ADDR_CHAIN:    prdata = {63'd0, chain_reg};
            default:       prdata = 64'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
            iv_high_reg  <= '0;
            iv_low_reg   <= '0;
            decrypt_reg  <= 1'b0;
            chain_reg    <= 1'b0;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                ADDR_KEY_HIGH: key_high_reg <= pwdata;
                ADDR_KEY_LOW:  key_low_reg  <= pwdata;
                ADDR_IV_HIGH:  iv_high_reg  <= pwdata;
                ADDR_IV_LOW:   iv_low_reg   <= pwdata;
                ADDR_DECRYPT:  decrypt_reg  <= pwdata[0];
                ADDR_CHAIN:    chain_reg    <= pwdata[0];
                default: ;
            endcase
        end
    end

    // round key memory, one write and one registered read per cycle;
    // a read of the entry being written returns the new key
    always_ff @(posedge clk)
    begin
        if (wr_en)
            rk_mem[wr_addr] <= wr_data;
        rk_rd <= (wr_en && wr_addr == rd_addr) ? wr_data : rk_mem[rd_addr];
    end

    assign t_word = x_reg[1] ^ x_reg[2] ^ x_reg[3] ^
                    ((state_reg == ST_EXPAND) ? ck_word(5'(cnt_reg)) : rk_rd);
    assign f_word = (state_reg == ST_EXPAND) ? lin_key(tau(t_word)) : lin_data(tau(t_word));

    // a final round result is x0 rotated in; words emitted as x3..x0 after last
    always_comb
    begin
        logic [31:0] nw;
        nw = x_reg[0] ^ f_word;
        fin_hi = {nw, x_reg[3]};
        fin_lo = {x_reg[2], x_reg[1]};
        if (chain_reg && decrypt_reg)
        begin
            fin_hi = fin_hi ^ chain_hi_reg;
            fin_lo = fin_lo ^ chain_lo_reg;
        end
    end

    always_comb
    begin
        logic [63:0] ch_hi, ch_lo, in_hi, in_lo;
        state_next = state_reg;
        cnt_next   = cnt_reg;
        x_next     = x_reg;
        wr_en      = 1'b0;
        wr_addr    = RW'(cnt_reg);
        wr_data    = x_reg[0] ^ f_word;
        rd_addr    = '0;
        ch_hi = first_block ? iv_high_reg : chain_hi_reg;
        ch_lo = first_block ? iv_low_reg  : chain_lo_reg;
        in_hi = (chain_reg && !decrypt_reg) ? block_high ^ ch_hi : block_high;
        in_lo = (chain_reg && !decrypt_reg) ? block_low  ^ ch_lo : block_low;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    cnt_next = '0;
                    if (!keys_ready_reg)
                    begin
                        state_next = ST_EXPAND;
                        x_next[0] = key_high_reg[63:32] ^ FK0;
                        x_next[1] = key_high_reg[31:0]  ^ FK1;
                        x_next[2] = key_low_reg[63:32]  ^ FK2;
                        x_next[3] = key_low_reg[31:0]   ^ FK3;
                    end
                    else
                    begin
                        state_next = ST_ROUND;
                        x_next = '{in_hi[63:32], in_hi[31:0], in_lo[63:32], in_lo[31:0]};
                    end
                    rd_addr = decrypt_reg ? RW'(ROUNDS - 1) : '0;
                end
            end
            ST_EXPAND:
            begin
                wr_en = 1'b1;
                x_next = '{x_reg[1], x_reg[2], x_reg[3], x_reg[0] ^ f_word};
                cnt_next = cnt_reg + 1'b1;
                rd_addr = decrypt_reg ? RW'(ROUNDS - 1) : '0;
                if (cnt_reg == (RW+1)'(ROUNDS - 1))
                begin
                    state_next = ST_ROUND;
                    cnt_next = '0;
                    x_next = '{blk_hi_reg[63:32], blk_hi_reg[31:0],
                               blk_lo_reg[63:32], blk_lo_reg[31:0]};
                end
            end
            ST_ROUND:
            begin
                x_next = '{x_reg[1], x_reg[2], x_reg[3], x_reg[0] ^ f_word};
                cnt_next = cnt_reg + 1'b1;
                rd_addr = decrypt_reg ? RW'(ROUNDS - 2) - RW'(cnt_reg)
                                      : RW'(cnt_reg) + 1'b1;
                if (cnt_reg == (RW+1)'(ROUNDS - 1))
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!oval_reg || !out_stall)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // x_reg packed on block entry during expansion holds the pre-chained block
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            keys_ready_reg <= 1'b0;
            chain_hi_reg   <= '0;
            chain_lo_reg   <= '0;
            oval_reg       <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (cfg_wr && (cfg_idx == ADDR_KEY_HIGH || cfg_idx == ADDR_KEY_LOW))
                keys_ready_reg <= 1'b0;
            else if (state_reg == ST_EXPAND)
                keys_ready_reg <= 1'b1;
            if (in_acc && first_block)
            begin
                chain_hi_reg <= iv_high_reg;
                chain_lo_reg <= iv_low_reg;
            end
            if (state_reg == ST_ROUND && cnt_reg == (RW+1)'(ROUNDS - 1) && chain_reg)
            begin
                if (decrypt_reg)
                begin
                    chain_hi_reg <= blk_hi_reg;
                    chain_lo_reg <= blk_lo_reg;
                end
                else
                begin
                    chain_hi_reg <= fin_hi;
                    chain_lo_reg <= fin_lo;
                end
            end
            if (state_reg == ST_DONE && (!oval_reg || !out_stall))
                oval_reg <= 1'b1;
            else if (oval_reg && !out_stall)
                oval_reg <= 1'b0;
        end
    end

    logic [63:0] res_hi_reg, res_lo_reg;

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        if (in_acc)
        begin
            last_reg <= final_block;
            if (!keys_ready_reg)
            begin
                // stash the block, with CBC encrypt chaining already applied
                blk_hi_reg <= (chain_reg && !decrypt_reg)
                    ? block_high ^ (first_block ? iv_high_reg : chain_hi_reg) : block_high;
                blk_lo_reg <= (chain_reg && !decrypt_reg)
                    ? block_low ^ (first_block ? iv_low_reg : chain_lo_reg) : block_low;
            end
            else
            begin
                blk_hi_reg <= block_high;
                blk_lo_reg <= block_low;
            end
        end
        if (state_reg == ST_EXPAND && cnt_reg == (RW+1)'(ROUNDS - 1) && chain_reg && decrypt_reg)
        begin
            blk_hi_reg <= blk_hi_reg;
            blk_lo_reg <= blk_lo_reg;
        end
        if (state_reg == ST_ROUND && cnt_reg == (RW+1)'(ROUNDS - 1))
        begin
            res_hi_reg <= fin_hi;
            res_lo_reg <= fin_lo;
        end
        if (state_reg == ST_DONE && (!oval_reg || !out_stall))
        begin
            ohi_reg <= res_hi_reg;
            olo_reg <= res_lo_reg;
            result_last <= last_reg;
        end
    end

    assign out_valid   = oval_reg;
    assign result_high = ohi_reg;
    assign result_low  = olo_reg;

    property p_busy_stall;
        @(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND) |-> in_stall;
    endproperty
    a_busy_stall: assert property (p_busy_stall) else $error("accept during rounds");

    property p_keys_after_expand;
        @(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXPAND && !cfg_wr) |=> keys_ready_reg;
    endproperty
    a_keys_after_expand: assert property (p_keys_after_expand)
        else $error("keys not marked ready");

    property p_round_from_ready;
        @(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && in_acc && keys_ready_reg) |=> (state_reg == ST_ROUND);
    endproperty
    a_round_from_ready: assert property (p_round_from_ready) else $error("bad start");

endmodule

/* tb/sv/tb_sm4_block_cipher_cbc.sv */
// Testbench for the SM4 ECB/CBC block cipher: random and directed blocks, scoreboard check.
`timescale 1ns / 1ps

class sm4_scoreboard;
    logic [63:0] key_hi, key_lo, iv_hi, iv_lo;
    bit          decrypt, cbc;
    logic [31:0] rkeys [32];
    bit          keys_valid;
    logic [63:0] chain_hi, chain_lo;
    logic [128:0] expected_blocks [$];
    int          errors;

    function new();
        key_hi = '0; key_lo = '0; iv_hi = '0; iv_lo = '0;
        decrypt = 0; cbc = 0; keys_valid = 0;
        chain_hi = '0; chain_lo = '0; errors = 0;
    endfunction

    function logic [31:0] sub_word(logic [31:0] v);
        return {sm4_pkg::SBOX[v[31:24]], sm4_pkg::SBOX[v[23:16]],
                sm4_pkg::SBOX[v[15:8]], sm4_pkg::SBOX[v[7:0]]};
    endfunction

    function logic [31:0] rol(logic [31:0] v, int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    function void note_write(logic [2:0] addr, logic [63:0] val);
        case (addr)
            sm4_pkg::ADDR_KEY_HIGH: begin key_hi = val; keys_valid = 0; end
            sm4_pkg::ADDR_KEY_LOW:  begin key_lo = val; keys_valid = 0; end
            sm4_pkg::ADDR_IV_HIGH:  iv_hi = val;
            sm4_pkg::ADDR_IV_LOW:   iv_lo = val;
            sm4_pkg::ADDR_DECRYPT:  decrypt = val[0];
            sm4_pkg::ADDR_CHAIN:    cbc = val[0];
            default: ;
        endcase
    endfunction

    function void schedule_keys();
        logic [31:0] k [4];
        logic [31:0] t, ck;
        logic [7:0] b;
        k[0] = key_hi[63:32] ^ 32'ha3b1bac6;
        k[1] = key_hi[31:0] ^ 32'h56aa3350;
        k[2] = key_lo[63:32] ^ 32'h677d9197;
        k[3] = key_lo[31:0] ^ 32'hb27022dc;
        for (int i = 0; i < 32; i++) begin
            ck = '0;
            for (int j = 0; j < 4; j++) begin
                b = 8'((4 * i + j) * 7);
                ck = {ck[23:0], b};
            end
            t = k[(i + 1) % 4] ^ k[(i + 2) % 4] ^ k[(i + 3) % 4] ^ ck;
            t = sub_word(t);
            k[i % 4] ^= t ^ rol(t, 13) ^ rol(t, 23);
            rkeys[i] = k[i % 4];
        end
        keys_valid = 1;
    endfunction

    function logic [127:0] crypt(logic [127:0] blk, bit dec);
        logic [31:0] x [4];
        logic [31:0] t;
        x[0] = blk[127:96]; x[1] = blk[95:64]; x[2] = blk[63:32]; x[3] = blk[31:0];
        for (int r = 0; r < 32; r++) begin
            t = x[(r + 1) % 4] ^ x[(r + 2) % 4] ^ x[(r + 3) % 4]
                ^ (dec ? rkeys[31 - r] : rkeys[r]);
            t = sub_word(t);
            x[r % 4] ^= t ^ rol(t, 2) ^ rol(t, 10) ^ rol(t, 18) ^ rol(t, 24);
        end
        return {x[3], x[2], x[1], x[0]};
    endfunction

    function void note_block(logic [63:0] bh, logic [63:0] bl, bit first, bit last);
        logic [127:0] res;
        if (!keys_valid) schedule_keys();
        if (first) begin chain_hi = iv_hi; chain_lo = iv_lo; end
        if (!cbc) res = crypt({bh, bl}, decrypt);
        else if (!decrypt) begin
            res = crypt({bh ^ chain_hi, bl ^ chain_lo}, 0);
            {chain_hi, chain_lo} = res;
        end else begin
            res = crypt({bh, bl}, 1) ^ {chain_hi, chain_lo};
            chain_hi = bh; chain_lo = bl;
        end
        expected_blocks.push_back({res, last});
    endfunction

    function void report(string what);
        $display("MISMATCH %s at %0t", what, $time);
        errors++;
    endfunction

    function void check_block(logic [63:0] rh, logic [63:0] rl, logic last);
        logic [128:0] e;
        if (expected_blocks.size() == 0) begin
            report("unexpected result beat");
            return;
        end
        e = expected_blocks.pop_front();
        if (rh !== e[128:65]) report($sformatf("result_high %h exp %h", rh, e[128:65]));
        if (rl !== e[64:1]) report($sformatf("result_low %h exp %h", rl, e[64:1]));
        if (last !== e[0]) report($sformatf("result_last %b exp %b", last, e[0]));
    endfunction
endclass

module tb_sm4_block_cipher_cbc;
    import sm4_pkg::*;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        psel = 0, penable = 0, pwrite = 0;
    logic [5:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;
    logic        in_valid = 0;
    logic        in_stall;
    logic [63:0] block_high = '0, block_low = '0;
    logic        first_block = 0, final_block = 0;
    logic        out_valid;
    logic        out_stall = 1;
    logic [63:0] result_high, result_low;
    logic        result_last;

    sm4_scoreboard sb = new();
    int  send_idle_pct, recv_idle_pct;
    int  hold_off;
    longint cycle_count;

    sm4_block_cipher_cbc u_dut (.*);

    always
    begin
        #2 clk = 1;
        #2 clk = 0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > 400000)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // result side: random stall, long hold-off when requested
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_block(result_high, result_low, result_last);
        if (hold_off > 0)
        begin
            hold_off <= hold_off - 1;
            out_stall <= 1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    task automatic cfg_write(logic [2:0] addr, logic [63:0] val);
        @(posedge clk);
        psel <= 1; penable <= 0; pwrite <= 1;
        paddr <= {addr, 3'b000}; pwdata <= val;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        sb.note_write(addr, val);
        psel <= 0; penable <= 0; pwrite <= 0;
    endtask

    task automatic send_block(logic [63:0] bh, logic [63:0] bl, bit first, bit last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(posedge clk);
            in_valid <= 0;
        end
        @(posedge clk);
        in_valid <= 1;
        block_high <= bh; block_low <= bl;
        first_block <= first; final_block <= last;
        do @(posedge clk); while (in_stall);
        sb.note_block(bh, bl, first, last);
        in_valid <= 0;
    endtask

    task automatic drain();
        while (sb.expected_blocks.size() != 0) @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    task automatic random_setup();
        cfg_write(ADDR_KEY_HIGH, rand64());
        cfg_write(ADDR_KEY_LOW, rand64());
        cfg_write(ADDR_IV_HIGH, rand64());
        cfg_write(ADDR_IV_LOW, rand64());
        cfg_write(ADDR_DECRYPT, $urandom_range(1));
        cfg_write(ADDR_CHAIN, $urandom_range(1));
    endtask

    // mostly messages: first block, random body, final block
    task automatic random_messages(int count);
        int n = 0;
        int len;
        while (n < count)
        begin
            if ($urandom_range(9) == 0)
            begin
                send_block(rand64(), rand64(), $urandom_range(1), $urandom_range(1));
                n++;
            end
            else
            begin
                len = $urandom_range(1, 8);
                for (int i = 0; i < len; i++)
                    send_block(rand64(), rand64(), i == 0, i == len - 1);
                n += len;
            end
        end
    endtask

    initial
    begin
        send_idle_pct = 0; recv_idle_pct = 0; hold_off = 0; cycle_count = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1;

        // reset defaults: zero key, ECB encrypt, chain value zero
        send_block('0, '0, 0, 0);
        send_block('1, '1, 0, 1);
        drain();
        // standard test vector
        cfg_write(ADDR_KEY_HIGH, 64'h0123456789abcdef);
        cfg_write(ADDR_KEY_LOW, 64'hfedcba9876543210);
        send_block(64'h0123456789abcdef, 64'hfedcba9876543210, 1, 1);
        drain();
        cfg_write(ADDR_DECRYPT, 1);
        send_block(64'h681edf34d206965e, 64'h86b3e94f536e4246, 0, 1);
        drain();
        // CBC both ways, all-ones IV, block without first uses leftover chain
        cfg_write(ADDR_CHAIN, 1);
        cfg_write(ADDR_IV_HIGH, '1);
        cfg_write(ADDR_IV_LOW, '1);
        send_block(64'h8000000000000001, 64'h0, 0, 0);
        send_block('1, '0, 1, 0);
        send_block('0, '1, 0, 1);
        send_block(rand64(), rand64(), 0, 0);
        drain();
        cfg_write(ADDR_DECRYPT, 0);
        send_block('0, '0, 1, 0);
        send_block('1, '1, 0, 1);
        send_block(rand64(), rand64(), 0, 0);
        drain();
        cfg_write(ADDR_KEY_HIGH, '1);
        cfg_write(ADDR_KEY_LOW, '1);
        send_block('1, '1, 1, 1);
        drain();

        send_idle_pct = 25; recv_idle_pct = 66;
        random_setup();
        random_messages(260);
        drain();
        // long receiver hold-off while blocks keep coming
        hold_off = 200;
        random_messages(10);
        drain();

        send_idle_pct = 66; recv_idle_pct = 25;
        random_setup();
        random_messages(260);
        drain();

        send_idle_pct = 0; recv_idle_pct = 0;
        random_setup();
        random_messages(260);
        drain();

        if (sb.errors == 0 && sb.expected_blocks.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
